// ===== design/jsu_pkg.sv =====
// Shared types, codes and UTF-8 helpers for the JSON string unescape block.
package jsu_pkg;

  localparam int unsigned MaxRes = 6;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);

  // Result status codes
  typedef enum logic [2:0] {
    ST_BYTE      = 3'd0,
    ST_DONE      = 3'd1,
    ST_EXP_QUOTE = 3'd2,
    ST_TRUNC_ESC = 3'd3,
    ST_TRUNC_UNI = 3'd4,
    ST_BAD_HEX   = 3'd5,
    ST_BAD_ESC   = 3'd6,
    ST_UNTERM    = 3'd7
  } status_e;

  // Decoder modes, one-hot
  typedef enum logic [8:0] {
    M_IDLE     = 9'b000000001,
    M_STR      = 9'b000000010,
    M_ESC      = 9'b000000100,
    M_UHEX     = 9'b000001000,
    M_UHEX_BAD = 9'b000010000,
    M_HI_BS    = 9'b000100000,
    M_HI_U     = 9'b001000000,
    M_LHEX     = 9'b010000000,
    M_LHEX_BAD = 9'b100000000
  } mode_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLowB = 8'h62;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChLowN = 8'h6E;
  localparam logic [7:0] ChLowR = 8'h72;
  localparam logic [7:0] ChLowT = 8'h74;
  localparam logic [7:0] ChLowU = 8'h75;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
  } ent_t;

  // Up to four entries, entry 0 first
  typedef struct packed {
    ent_t [3:0]  ent;
    logic [2:0]  n;
  } seq_t;

  // Full result list of one item, entry 0 first
  typedef struct packed {
    ent_t [MaxRes-1:0] ent;
    logic [ResCntW-1:0] n;
  } res_t;

  function automatic seq_t byte_seq(logic [7:0] b);
    seq_t s;
    s = '0;
    s.ent[0].data = b;
    s.ent[0].status = ST_BYTE;
    s.n = 3'd1;
    return s;
  endfunction

  function automatic seq_t status_seq(status_e st);
    seq_t s;
    s = '0;
    s.ent[0].status = st;
    s.n = 3'd1;
    return s;
  endfunction

  function automatic seq_t utf8_seq(logic [20:0] cp);
    seq_t s;
    s = '0;
    if (cp < 21'h80) begin
      s.ent[0].data = cp[7:0];
      s.n = 3'd1;
    end else if (cp < 21'h800) begin
      s.ent[0].data = {3'b110, cp[10:6]};
      s.ent[1].data = {2'b10, cp[5:0]};
      s.n = 3'd2;
    end else if (cp < 21'h10000) begin
      s.ent[0].data = {4'b1110, cp[15:12]};
      s.ent[1].data = {2'b10, cp[11:6]};
      s.ent[2].data = {2'b10, cp[5:0]};
      s.n = 3'd3;
    end else begin
      s.ent[0].data = {5'b11110, cp[20:18]};
      s.ent[1].data = {2'b10, cp[17:12]};
      s.ent[2].data = {2'b10, cp[11:6]};
      s.ent[3].data = {2'b10, cp[5:0]};
      s.n = 3'd4;
    end
    return s;
  endfunction

  // Returns {valid, nibble}; nibble is zero for a non-hex byte
  function automatic logic [4:0] hex_nib(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) r = {1'b1, c[3:0]};
    else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

// ===== design/jsu_decode.sv =====
// Decode state and per-item result list for the JSON string unescape block.
module jsu_decode import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] byte_i,
  input  logic       eot_i,
  output res_t       res_o
);

  typedef struct packed {
    mode_e mode;
    seq_t  seq;
  } step_t;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] code_q, code_d;
  logic [15:0] held_q, held_d;
  logic [15:0] low_q, low_d;

  logic        pre;
  seq_t        tail;
  seq_t        held_seq;
  step_t       st;
  logic [4:0]  hx;
  logic        bad;
  logic [15:0] code_sh, low_sh;

  function automatic step_t str_step(logic [7:0] c);
    step_t s;
    s = '0;
    if (c == ChQuote) begin
      s.mode = M_IDLE;
      s.seq = status_seq(ST_DONE);
    end else if (c == ChBslash) begin
      s.mode = M_ESC;
    end else begin
      s.mode = M_STR;
      s.seq = byte_seq(c);
    end
    return s;
  endfunction

  function automatic step_t esc_step(logic [7:0] c);
    step_t s;
    s = '0;
    s.mode = M_STR;
    case (c)
      ChQuote, ChBslash, ChSlash: s.seq = byte_seq(c);
      ChLowB: s.seq = byte_seq(8'h08);
      ChLowF: s.seq = byte_seq(8'h0C);
      ChLowN: s.seq = byte_seq(8'h0A);
      ChLowR: s.seq = byte_seq(8'h0D);
      ChLowT: s.seq = byte_seq(8'h09);
      ChLowU: s.mode = M_UHEX;
      default: begin
        s.mode = M_IDLE;
        s.seq = status_seq(ST_BAD_ESC);
      end
    endcase
    return s;
  endfunction

  assign hx       = hex_nib(byte_i);
  assign code_sh  = {code_q[11:0], hx[3:0]};
  assign low_sh   = {low_q[11:0], hx[3:0]};
  assign held_seq = utf8_seq({5'd0, held_q});

  always_comb begin
    mode_d    = mode_q;
    hex_cnt_d = hex_cnt_q;
    code_d    = code_q;
    held_d    = held_q;
    low_d     = low_q;
    pre       = 1'b0;
    tail      = '0;
    st        = '0;
    bad       = 1'b0;
    case (mode_q)
      M_IDLE: begin
        if (!eot_i && byte_i == ChQuote) mode_d = M_STR;
        else tail = status_seq(ST_EXP_QUOTE);
      end
      M_STR: begin
        if (eot_i) begin
          tail = status_seq(ST_UNTERM);
          mode_d = M_IDLE;
        end else begin
          st = str_step(byte_i);
          mode_d = st.mode;
          tail = st.seq;
        end
      end
      M_ESC: begin
        if (eot_i) begin
          tail = status_seq(ST_TRUNC_ESC);
          mode_d = M_IDLE;
        end else begin
          st = esc_step(byte_i);
          mode_d = st.mode;
          tail = st.seq;
          if (byte_i == ChLowU) begin
            hex_cnt_d = '0;
            code_d = '0;
          end
        end
      end
      M_UHEX, M_UHEX_BAD: begin
        if (eot_i) begin
          tail = status_seq(ST_TRUNC_UNI);
          mode_d = M_IDLE;
        end else begin
          bad = (mode_q == M_UHEX_BAD) || !hx[4];
          code_d = code_sh;
          if (hex_cnt_q != 2'd3) begin
            hex_cnt_d = hex_cnt_q + 2'd1;
            mode_d = bad ? M_UHEX_BAD : M_UHEX;
          end else begin
            hex_cnt_d = '0;
            if (bad) begin
              tail = status_seq(ST_BAD_HEX);
              mode_d = M_IDLE;
            end else if (code_sh inside {[16'hD800:16'hDBFF]}) begin
              held_d = code_sh;
              mode_d = M_HI_BS;
            end else begin
              tail = utf8_seq({5'd0, code_sh});
              mode_d = M_STR;
            end
          end
        end
      end
      M_HI_BS: begin
        if (eot_i) begin
          pre = 1'b1;
          tail = status_seq(ST_UNTERM);
          mode_d = M_IDLE;
        end else if (byte_i == ChBslash) begin
          mode_d = M_HI_U;
        end else begin
          // flush the held surrogate, then treat the byte as plain text
          pre = 1'b1;
          st = str_step(byte_i);
          mode_d = st.mode;
          tail = st.seq;
        end
      end
      M_HI_U: begin
        if (eot_i) begin
          pre = 1'b1;
          tail = status_seq(ST_TRUNC_ESC);
          mode_d = M_IDLE;
        end else if (byte_i == ChLowU) begin
          mode_d = M_LHEX;
          hex_cnt_d = '0;
          low_d = '0;
        end else begin
          pre = 1'b1;
          st = esc_step(byte_i);
          mode_d = st.mode;
          tail = st.seq;
        end
      end
      M_LHEX, M_LHEX_BAD: begin
        if (eot_i) begin
          pre = 1'b1;
          tail = status_seq(ST_TRUNC_UNI);
          mode_d = M_IDLE;
        end else begin
          bad = (mode_q == M_LHEX_BAD) || !hx[4];
          low_d = low_sh;
          if (hex_cnt_q != 2'd3) begin
            hex_cnt_d = hex_cnt_q + 2'd1;
            mode_d = bad ? M_LHEX_BAD : M_LHEX;
          end else begin
            hex_cnt_d = '0;
            if (!bad && (low_sh inside {[16'hDC00:16'hDFFF]})) begin
              // join the pair into one supplementary code point
              tail = utf8_seq(21'h10000 + {1'b0, held_q[9:0], low_sh[9:0]});
              mode_d = M_STR;
            end else if (bad) begin
              pre = 1'b1;
              tail = status_seq(ST_BAD_HEX);
              mode_d = M_IDLE;
            end else if (low_sh inside {[16'hD800:16'hDBFF]}) begin
              pre = 1'b1;
              held_d = low_sh;
              mode_d = M_HI_BS;
            end else begin
              pre = 1'b1;
              tail = utf8_seq({5'd0, low_sh});
              mode_d = M_STR;
            end
          end
        end
      end
      default: mode_d = M_IDLE;
    endcase
  end

  // Merge the held-surrogate bytes ahead of the tail
  always_comb begin
    res_o = '0;
    if (pre) begin
      res_o.ent[2:0] = held_seq.ent[2:0];
      res_o.ent[5:3] = tail.ent[2:0];
      res_o.n = ResCntW'(tail.n) + ResCntW'(3);
    end else begin
      res_o.ent[3:0] = tail.ent;
      res_o.n = ResCntW'(tail.n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_IDLE;
      hex_cnt_q <= '0;
      code_q    <= '0;
      held_q    <= '0;
      low_q     <= '0;
    end else if (en_i) begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      code_q    <= code_d;
      held_q    <= held_d;
      low_q     <= low_d;
    end
  end

endmodule

// ===== design/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescape to UTF-8 decoder.
//
//   channel | direction | payload                              | handshake
//   in      | sink      | in_byte_i, end_of_text_i             | in_valid_i / in_ready_o
//   out     | source    | out_byte_o, out_status_o, out_last_o | out_valid_o / out_ready_i
//
// An accepted item sits in the input register, is decoded combinationally and
// its whole result list (0 to 6 entries) is loaded into the result buffer.
// Results leave one per cycle while out_ready_i is high, and an item holds the
// decoder until its last result leaves, so plain bytes stream at one item per cycle.
// The input register takes a new item while the buffer still drains.
// Reset returns the decoder to idle and empties both registers.
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] out_status_o,
  output logic       out_last_o
);

  logic               in_full_q;
  logic [7:0]         in_byte_q;
  logic               in_eot_q;
  logic               dec_fire;
  logic               rbuf_free;
  logic               out_xfer;
  res_t               res;
  ent_t [MaxRes-1:0]  rbuf_q, rbuf_d;
  logic [ResCntW-1:0] cnt_q, cnt_d;

  assign out_xfer   = out_valid_o && out_ready_i;
  assign rbuf_free  = (cnt_q == '0) || ((cnt_q == ResCntW'(1)) && out_ready_i);
  assign dec_fire   = in_full_q && rbuf_free;
  assign in_ready_o = !in_full_q || dec_fire;

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (dec_fire),
    .byte_i (in_byte_q),
    .eot_i  (in_eot_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_full_q <= 1'b1;
    end else if (dec_fire) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_eot_q  <= end_of_text_i;
    end
  end

  // Load a fresh result list, or advance the buffer on each transfer
  always_comb begin
    rbuf_d = rbuf_q;
    cnt_d  = cnt_q;
    if (dec_fire) begin
      rbuf_d = res.ent;
      cnt_d  = res.n;
    end else if (out_xfer) begin
      for (int i = 0; i < MaxRes - 1; i++) rbuf_d[i] = rbuf_q[i+1];
      rbuf_d[MaxRes-1] = '0;
      cnt_d = cnt_q - ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    rbuf_q <= rbuf_d;
  end

  assign out_valid_o  = (cnt_q != '0);
  assign out_byte_o   = rbuf_q[0].data;
  assign out_status_o = rbuf_q[0].status;
  assign out_last_o   = (cnt_q == ResCntW'(1));

endmodule

// ===== design/jsu_checker.sv =====
// Port-level checks for the JSON string unescape decoder, bound to the top level.
module jsu_checker import jsu_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [2:0] out_status_o,
  input logic       out_last_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(out_status_o) && $stable(out_last_o))
    else $error("stalled result changed");

  // Done and error results always close an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != ST_BYTE) |-> out_last_o)
    else $error("status result not marked last");

  // Non-byte results carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != ST_BYTE) |-> out_byte_o == 8'd0)
    else $error("status result carries a byte");

  // The rest of an item's results follow without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_last_o |=> out_valid_o)
    else $error("gap inside a result burst");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the JSON string unescape to UTF-8 decoder.
module tb_top;
  import jsu_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomItems = 190;
  localparam logic [15:0] HiFirst = 16'hD800;
  localparam logic [15:0] HiLast = 16'hDBFF;
  localparam logic [15:0] LoFirst = 16'hDC00;
  localparam logic [15:0] LoLast = 16'hDFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic [1:0] phase;
  } text_item_t;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } out_rec_t;

  typedef enum logic [3:0] {
    DS_WAIT_OPEN,
    DS_TEXT,
    DS_ESCAPE,
    DS_HEX,
    DS_HEX_BAD,
    DS_HI_WAIT_BSLASH,
    DS_HI_WAIT_U,
    DS_LOW_HEX,
    DS_LOW_HEX_BAD
  } dec_state_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [2:0] out_status_o;
  logic       out_last_o;

  text_item_t pending_q [$];
  out_rec_t   decoded_q [$];
  out_rec_t   item_res [$];
  int         n_items = 0;
  int         accepted_cnt = 0;
  int         err_cnt = 0;
  int         cycle_cnt = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  logic [1:0] cur_phase = 2'd0;
  text_item_t nxt;
  out_rec_t   want;
  out_rec_t   got;

  // Decoder state mirror
  dec_state_e  dstate = DS_WAIT_OPEN;
  logic [1:0]  digit_cnt = 2'd0;
  logic [15:0] unit_acc = 16'h0000;
  logic [15:0] held_hi = 16'h0000;
  logic [15:0] low_unit = 16'h0000;

  json_string_unescape_utf8 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .out_status_o  (out_status_o),
    .out_last_o    (out_last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // Returns {not_hex, nibble}; nibble is zero for a non-hex byte
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
    else return 5'h10;
    return {1'b0, d[3:0]};
  endfunction

  task automatic emit(input logic [7:0] b, input status_e st);
    out_rec_t r;
    if (item_res.size() < MaxRes) begin
      r.data = (st == ST_BYTE) ? b : 8'h00;
      r.status = st;
      r.last = 1'b0;
      item_res.insert(item_res.size(), r);
    end
  endtask

  task automatic emit_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0], ST_BYTE);
    end else if (cp < 21'h800) begin
      emit(8'hC0 | {3'b0, cp[10:6]}, ST_BYTE);
      emit(8'h80 | {2'b0, cp[5:0]}, ST_BYTE);
    end else if (cp < 21'h10000) begin
      emit(8'hE0 | {4'b0, cp[15:12]}, ST_BYTE);
      emit(8'h80 | {2'b0, cp[11:6]}, ST_BYTE);
      emit(8'h80 | {2'b0, cp[5:0]}, ST_BYTE);
    end else begin
      emit(8'hF0 | {5'b0, cp[20:18]}, ST_BYTE);
      emit(8'h80 | {2'b0, cp[17:12]}, ST_BYTE);
      emit(8'h80 | {2'b0, cp[11:6]}, ST_BYTE);
      emit(8'h80 | {2'b0, cp[5:0]}, ST_BYTE);
    end
  endtask

  task automatic abort(input status_e st);
    emit(8'h00, st);
    dstate = DS_WAIT_OPEN;
  endtask

  // Hold a high surrogate until the next escape shows whether it pairs
  task automatic take_unit(input logic [15:0] u);
    if (u >= HiFirst && u <= HiLast) begin
      held_hi = u;
      dstate = DS_HI_WAIT_BSLASH;
    end else begin
      emit_cp({5'b0, u});
      dstate = DS_TEXT;
    end
  endtask

  task automatic text_byte(input logic [7:0] c);
    if (c == ChQuote) begin
      emit(8'h00, ST_DONE);
      dstate = DS_WAIT_OPEN;
    end else if (c == ChBslash) begin
      dstate = DS_ESCAPE;
    end else begin
      emit(c, ST_BYTE);
    end
  endtask

  task automatic escape_byte(input logic [7:0] c);
    dstate = DS_TEXT;
    case (c)
      ChQuote:  emit(ChQuote, ST_BYTE);
      ChBslash: emit(ChBslash, ST_BYTE);
      ChSlash:  emit(ChSlash, ST_BYTE);
      ChLowB:   emit(8'h08, ST_BYTE);
      ChLowF:   emit(8'h0C, ST_BYTE);
      ChLowN:   emit(8'h0A, ST_BYTE);
      ChLowR:   emit(8'h0D, ST_BYTE);
      ChLowT:   emit(8'h09, ST_BYTE);
      ChLowU: begin
        dstate = DS_HEX;
        digit_cnt = 2'd0;
        unit_acc = 16'h0000;
      end
      default:  abort(ST_BAD_ESC);
    endcase
  endtask

  task automatic predict(input logic [7:0] c, input logic eot);
    logic [4:0]  hv;
    logic [20:0] pair_cp;
    out_rec_t    rec;
    item_res.delete();
    hv = hex_val(c);
    if (eot) begin
      case (dstate)
        DS_TEXT:             abort(ST_UNTERM);
        DS_ESCAPE:           abort(ST_TRUNC_ESC);
        DS_HEX, DS_HEX_BAD:  abort(ST_TRUNC_UNI);
        DS_HI_WAIT_BSLASH: begin
          emit_cp({5'b0, held_hi});
          abort(ST_UNTERM);
        end
        DS_HI_WAIT_U: begin
          emit_cp({5'b0, held_hi});
          abort(ST_TRUNC_ESC);
        end
        DS_LOW_HEX, DS_LOW_HEX_BAD: begin
          emit_cp({5'b0, held_hi});
          abort(ST_TRUNC_UNI);
        end
        default:             abort(ST_EXP_QUOTE);
      endcase
    end else begin
      case (dstate)
        DS_TEXT:   text_byte(c);
        DS_ESCAPE: escape_byte(c);
        DS_HEX, DS_HEX_BAD: begin
          // a bad digit is only reported once all four have arrived
          if (hv[4]) dstate = DS_HEX_BAD;
          unit_acc = {unit_acc[11:0], hv[3:0]};
          if (digit_cnt != 2'd3) begin
            digit_cnt = digit_cnt + 2'd1;
          end else begin
            digit_cnt = 2'd0;
            if (dstate == DS_HEX_BAD) abort(ST_BAD_HEX);
            else take_unit(unit_acc);
          end
        end
        DS_HI_WAIT_BSLASH: begin
          if (c == ChBslash) begin
            dstate = DS_HI_WAIT_U;
          end else begin
            emit_cp({5'b0, held_hi});
            dstate = DS_TEXT;
            text_byte(c);
          end
        end
        DS_HI_WAIT_U: begin
          if (c == ChLowU) begin
            dstate = DS_LOW_HEX;
            digit_cnt = 2'd0;
            low_unit = 16'h0000;
          end else begin
            emit_cp({5'b0, held_hi});
            escape_byte(c);
          end
        end
        DS_LOW_HEX, DS_LOW_HEX_BAD: begin
          if (hv[4]) dstate = DS_LOW_HEX_BAD;
          low_unit = {low_unit[11:0], hv[3:0]};
          if (digit_cnt != 2'd3) begin
            digit_cnt = digit_cnt + 2'd1;
          end else begin
            digit_cnt = 2'd0;
            if (dstate == DS_LOW_HEX && low_unit >= LoFirst && low_unit <= LoLast) begin
              pair_cp = 21'h10000 + {1'b0, held_hi[9:0], low_unit[9:0]};
              emit_cp(pair_cp);
              dstate = DS_TEXT;
            end else if (dstate == DS_LOW_HEX_BAD) begin
              emit_cp({5'b0, held_hi});
              abort(ST_BAD_HEX);
            end else begin
              // no pair: flush the held unit, then treat this one on its own
              emit_cp({5'b0, held_hi});
              take_unit(low_unit);
            end
          end
        end
        default: begin
          if (c == ChQuote) dstate = DS_TEXT;
          else abort(ST_EXP_QUOTE);
        end
      endcase
    end
    if (item_res.size() != 0) begin
      rec = item_res[item_res.size() - 1];
      rec.last = 1'b1;
      item_res[item_res.size() - 1] = rec;
    end
    foreach (item_res[k]) decoded_q.insert(decoded_q.size(), item_res[k]);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.data = b;
    it.eot = eot;
    it.phase = 2'(n_items / 30);
    pending_q.insert(pending_q.size(), it);
    n_items++;
  endtask

  task automatic add_eot();
    add(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    if ($urandom_range(0, 1) != 0) return 8'h41 + nib - 8'd10;
    return 8'h61 + nib - 8'd10;
  endfunction

  task automatic add_digits(input logic [15:0] v, input int cnt);
    for (int k = 3; k > 3 - cnt; k--) add(hex_char(v[k*4 +: 4]), 1'b0);
  endtask

  task automatic add_u(input logic [15:0] v);
    add(ChBslash, 1'b0);
    add(ChLowU, 1'b0);
    add_digits(v, 4);
  endtask

  function automatic logic [15:0] rand_high();
    return 16'($urandom_range(HiFirst, HiLast));
  endfunction

  task automatic add_bad_hex();
    logic [7:0] c;
    logic [4:0] hv;
    int         pos;
    pos = $urandom_range(0, 3);
    add(ChBslash, 1'b0);
    add(ChLowU, 1'b0);
    for (int k = 0; k < 4; k++) begin
      if (k == pos) begin
        c = 8'($urandom_range(0, 255));
        hv = hex_val(c);
        while (!hv[4]) begin
          c = 8'($urandom_range(0, 255));
          hv = hex_val(c);
        end
        add(c, 1'b0);
      end else begin
        add(hex_char(4'($urandom_range(0, 15))), 1'b0);
      end
    end
  endtask

  task automatic gen_string();
    logic [7:0]  c;
    logic [15:0] v;
    logic        open;
    int          nseg;
    int          kind;
    open = 1'b1;
    add(ChQuote, 1'b0);
    nseg = $urandom_range(1, 8);
    for (int i = 0; i < nseg && open; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        c = 8'($urandom_range(0, 255));
        if (c == ChQuote || c == ChBslash) c = c ^ 8'h01;
        add(c, 1'b0);
      end else if (kind < 55) begin
        add(ChBslash, 1'b0);
        case ($urandom_range(0, 7))
          0: add(ChQuote, 1'b0);
          1: add(ChBslash, 1'b0);
          2: add(ChSlash, 1'b0);
          3: add(ChLowB, 1'b0);
          4: add(ChLowF, 1'b0);
          5: add(ChLowN, 1'b0);
          6: add(ChLowR, 1'b0);
          default: add(ChLowT, 1'b0);
        endcase
      end else if (kind < 68) begin
        case ($urandom_range(0, 2))
          0: v = 16'($urandom_range(16'h0000, 16'h007F));
          1: v = 16'($urandom_range(16'h0080, 16'h07FF));
          default: begin
            v = 16'($urandom_range(16'h0800, 16'hF7FF));
            if (v >= HiFirst) v = v + 16'h0800;
          end
        endcase
        add_u(v);
      end else if (kind < 80) begin
        add_u(rand_high());
        add_u(16'($urandom_range(LoFirst, LoLast)));
      end else if (kind < 86) begin
        add_u(rand_high());
      end else if (kind < 89) begin
        add_u(16'($urandom_range(LoFirst, LoLast)));
      end else if (kind < 92) begin
        if ($urandom_range(0, 1) != 0) add_u(rand_high());
        add_bad_hex();
        open = 1'b0;
      end else if (kind < 95) begin
        if ($urandom_range(0, 3) == 0) add_u(rand_high());
        add(ChBslash, 1'b0);
        c = 8'($urandom_range(0, 255));
        while (c == ChQuote || c == ChBslash || c == ChSlash || c == ChLowB ||
               c == ChLowF || c == ChLowN || c == ChLowR || c == ChLowT || c == ChLowU)
          c = 8'($urandom_range(0, 255));
        add(c, 1'b0);
        open = 1'b0;
      end else begin
        // cut the text short inside an escape
        case ($urandom_range(0, 4))
          0: add(ChBslash, 1'b0);
          1: begin
            add(ChBslash, 1'b0);
            add(ChLowU, 1'b0);
            add_digits(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
          end
          2: begin
            add_u(rand_high());
            add(ChBslash, 1'b0);
          end
          3: begin
            add_u(rand_high());
            add(ChBslash, 1'b0);
            add(ChLowU, 1'b0);
            add_digits(16'($urandom_range(LoFirst, LoLast)), $urandom_range(0, 3));
          end
          default: add_u(rand_high());
        endcase
        add_eot();
        open = 1'b0;
      end
    end
    if (open) begin
      if ($urandom_range(0, 19) < 17) add(ChQuote, 1'b0);
      else add_eot();
    end
    // occasional noise between strings
    case ($urandom_range(0, 9))
      0: begin
        c = 8'($urandom_range(0, 255));
        if (c == ChQuote) c = c ^ 8'h80;
        add(c, 1'b0);
      end
      1: add_eot();
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- idling

  function automatic int tx_idle_pct(logic [1:0] ph);
    case (ph)
      2'd1: return 51;
      2'd3: return 15;
      default: return 0;
    endcase
  endfunction

  function automatic int rx_stall_pct(logic [1:0] ph);
    case (ph)
      2'd2: return 51;
      2'd3: return 15;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict(in_byte_i, end_of_text_i);
        accepted_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() != 0 &&
            $urandom_range(0, 99) >= tx_idle_pct(pending_q[0].phase)) begin
          nxt = pending_q.pop_front();
          cur_phase <= nxt.phase;
          in_byte_i <= nxt.data;
          end_of_text_i <= nxt.eot;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("[%0d] %s", cycle_cnt, msg);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.data = out_byte_o;
        got.status = status_e'(out_status_o);
        got.last = out_last_o;
        if (decoded_q.size() == 0) begin
          note_error($sformatf("unexpected transfer: byte %02h status %0d last %0b",
                               got.data, got.status, got.last));
        end else begin
          want = decoded_q.pop_front();
          if (got != want)
            note_error($sformatf(
              "mismatch: expected byte %02h status %0d last %0b, got %02h %0d %0b",
              want.data, want.status, want.last, got.data, got.status, got.last));
        end
      end
      out_ready_i <= (hold_left == 0) &&
                     ($urandom_range(0, 99) >= rx_stall_pct(cur_phase));
    end
  end

  // Long receiver hold-off once, so the input side backs up
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && cycle_cnt == 40) begin
      hold_left <= 120;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // idle: stray byte and end mark
    add(8'h41, 1'b0);
    add_eot();
    // byte extremes, then end inside plain text
    add(ChQuote, 1'b0);
    add(8'h00, 1'b0);
    add(8'hFF, 1'b0);
    add_eot();
    // largest surrogate pair, then end right after a backslash
    add(ChQuote, 1'b0);
    add_u(16'hDBFF);
    add_u(16'hDFFF);
    add(ChBslash, 1'b0);
    add_eot();
    // lone high surrogate closed by the quote
    add(ChQuote, 1'b0);
    add_u(HiFirst);
    add(ChQuote, 1'b0);

    begin
      int n_directed;
      n_directed = n_items;
      while (n_items < n_directed + RandomItems) gen_string();
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt != n_items) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
